### rtl/core/phsc_pkg.sv
// Package for the pooled hash shared context counter.
// Widths, request, status and register codes, and the memory word types.
// No dependencies.
package phsc_pkg;

  localparam int unsigned TUP_W   = 52;
  localparam int unsigned GEN_W   = 11;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SLOT_W  = 16;
  localparam int unsigned PRB_W   = 17;
  localparam int unsigned HWORD_W = 64;

  localparam logic [SLOT_W-1:0] TABLE_SIZE  = 16'd65521;
  localparam logic [SLOT_W-1:0] TABLE_LAST  = 16'd65520;
  localparam logic [PRB_W-1:0]  TABLE_PRB   = 17'd65521;
  localparam logic [GEN_W-1:0]  GENOME_LAST = 11'd2047;
  localparam int unsigned       CNT_DEPTH   = 2048;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 16'hFFFF;

  // request kinds
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic CFG_OBJ_MASK   = 1'b0;
  localparam logic CFG_TUPLE_MASK = 1'b1;

  // counter memory word; an entry counts only when its epoch is the current genome
  typedef struct packed {
    logic [GEN_W-1:0] epoch;
    logic [CNT_W-1:0] ctx;
    logic [CNT_W-1:0] obj;
  } cnt_word_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [HWORD_W-1:0] wdata;
    logic               re;
    logic [SLOT_W-1:0]  raddr;
  } hash_port_t;

  typedef struct packed {
    logic             we;
    logic [GEN_W-1:0] waddr;
    cnt_word_t        wdata;
    logic             re;
    logic [GEN_W-1:0] raddr;
  } cnt_port_t;

endpackage

### rtl/core/phsc_hash_ram.sv
// Slot memory of the hash table: one write and one registered read port.
// Depends on phsc_pkg.
module phsc_hash_ram (
  input  logic                         clk,
  input  phsc_pkg::hash_port_t         port,
  output logic [phsc_pkg::HWORD_W-1:0] rdata
);
  import phsc_pkg::*;

  logic [HWORD_W-1:0] mem [0:TABLE_LAST];

  // write port
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (port.re) begin
      rdata <= mem[port.raddr];
    end
  end
endmodule

### rtl/core/phsc_cnt_ram.sv
// Per-genome counter memory, epoch tagged: one write and one registered read port.
// Depends on phsc_pkg.
module phsc_cnt_ram (
  input  logic                clk,
  input  phsc_pkg::cnt_port_t port,
  output phsc_pkg::cnt_word_t rdata
);
  import phsc_pkg::*;

  cnt_word_t mem [0:CNT_DEPTH-1];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (port.re) begin
      rdata <= mem[port.raddr];
    end
  end
endmodule

### rtl/core/phsc_mod.sv
// Two-stage remainder unit: context mod 65521 and mod 65520 in parallel.
// Depends on phsc_pkg.
module phsc_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [phsc_pkg::TUP_W-1:0]  ctx,
  output logic                        done,
  output logic [phsc_pkg::SLOT_W-1:0] rem_t,
  output logic [phsc_pkg::SLOT_W-1:0] rem_t1
);
  import phsc_pkg::*;

  logic [15:0]       a0, a1, a2;
  logic [3:0]        a3;
  logic [23:0]       y1_r, y1_nxt;
  logic [24:0]       y2_r, y2_nxt;
  logic [16:0]       f1, f2;
  logic [SLOT_W-1:0] r1_r, r2_r;
  logic              v_r, done_r;

  // 16-bit digits of the context
  assign a0 = ctx[15:0];
  assign a1 = ctx[31:16];
  assign a2 = ctx[47:32];
  assign a3 = ctx[TUP_W-1:48];

  // first fold: 2^16 is 15 mod 65521 and 16 mod 65520
  assign y1_nxt = 24'(a0) + 24'(a1) * 24'd15 + 24'(a2) * 24'd225 + 24'(a3) * 24'd3375;
  assign y2_nxt = 25'(a0) + {5'd0, a1, 4'd0} + {1'b0, a2, 8'd0} + {9'd0, a3, 12'd0};

  // second fold, below twice the modulus
  assign f1 = 17'(y1_r[15:0]) + 17'(y1_r[23:16]) * 17'd15;
  assign f2 = 17'(y2_r[15:0]) + {4'd0, y2_r[24:16], 4'd0};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v_r    <= start;
      done_r <= v_r;
    end
  end

  // datapath: fold, then one conditional subtract
  always_ff @(posedge clk) begin
    if (start) begin
      y1_r <= y1_nxt;
      y2_r <= y2_nxt;
    end
    if (v_r) begin
      r1_r <= (f1 >= {1'b0, TABLE_SIZE}) ? SLOT_W'(f1 - {1'b0, TABLE_SIZE}) : f1[SLOT_W-1:0];
      r2_r <= (f2 >= {1'b0, TABLE_LAST}) ? SLOT_W'(f2 - {1'b0, TABLE_LAST}) : f2[SLOT_W-1:0];
    end
  end

  assign done   = done_r;
  assign rem_t  = r1_r;
  assign rem_t1 = r2_r;
endmodule

### rtl/core/pooled_hash_shared_context_counter_top.sv
// Top level of the pooled hash shared context counter.
// Depends on phsc_pkg, phsc_mod, phsc_hash_ram, phsc_cnt_ram.
//
// One request is handled at a time. After reset a clearing pass writes every
// one of the 65521 table slots (and the counter memory) to zero, during which
// in_tready stays low; configuration writes are taken at any time. An insert
// first computes the two hash remainders (start, fold, reduce), then reads and
// checks one slot of the slot memory per probe, with a counter read-modify-write
// for each counted shared context, and then posts the result; the number of
// probes depends on table occupancy.
module pooled_hash_shared_context_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  // input: tuser = req_type[1:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: tuple_value[51:0], genome_select[62:52], zero[63]
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  // result: tdata = status[1:0], shared_ctx_count[17:2],
  // diff_obj_count[33:18], genome_number[44:34], zero[47:45]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // configuration: index 0 obj_mask, 1 tuple_mask
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [51:0] cfg_data
);
  import phsc_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EV   = 3'd4;
  localparam logic [2:0] S_CRD  = 3'd5;
  localparam logic [2:0] S_RRD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] sweep_r, sweep_nxt;
  logic [GEN_W-1:0]  cur_r, cur_nxt;
  logic [TUP_W-1:0]  obj_mask_r, tuple_mask_r;
  logic              out_valid_r, out_valid_nxt;
  logic [47:0]       out_data_r, out_data_nxt;

  logic [TUP_W-1:0]  tuple_r, tuple_nxt, ctx_r, ctx_nxt;
  logic [SLOT_W-1:0] h1_r, h1_nxt, h2_r, h2_nxt, off_r, off_nxt, slot_r, slot_nxt;
  logic [PRB_W-1:0]  probes_r, probes_nxt;
  logic [GEN_W-1:0]  g_r, g_nxt;
  logic              diff_r, diff_nxt, fail_r, fail_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [CNT_W-1:0]  res_sc_r, res_sc_nxt, res_dc_r, res_dc_nxt;

  hash_port_t         hport;
  cnt_port_t          cport;
  logic [HWORD_W-1:0] hrdata;
  cnt_word_t          crdata;
  logic               mod_start, mod_done;
  logic [SLOT_W-1:0]  rem_t, rem_t1;

  // start the remainder unit the cycle after the context is latched
  logic               hash_go_r;

  // probe helpers
  logic [GEN_W-1:0]  word_gen;
  logic [TUP_W-1:0]  word_tup;
  logic [SLOT_W:0]   off_sum, slot_sum;
  logic [SLOT_W-1:0] off_wrap, jump_slot, lin_slot;
  logic [PRB_W-1:0]  probes_inc;
  logic              ctx_hit, cnt_live;
  logic [CNT_W-1:0]  cur_ctx, cur_obj;

  phsc_mod u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .ctx    (ctx_r),
    .done   (mod_done),
    .rem_t  (rem_t),
    .rem_t1 (rem_t1)
  );

  phsc_hash_ram u_hash (
    .clk   (clk),
    .port  (hport),
    .rdata (hrdata)
  );

  phsc_cnt_ram u_cnt (
    .clk   (clk),
    .port  (cport),
    .rdata (crdata)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // next probe positions: double-hash jump and linear step
  assign word_gen   = hrdata[TUP_W+GEN_W-1:TUP_W];
  assign word_tup   = hrdata[TUP_W-1:0];
  assign ctx_hit    = ((word_tup & obj_mask_r) == ctx_r);
  assign off_sum    = {1'b0, off_r} + {1'b0, h2_r};
  assign off_wrap   = (off_sum >= {1'b0, TABLE_SIZE}) ?
                      SLOT_W'(off_sum - {1'b0, TABLE_SIZE}) : off_sum[SLOT_W-1:0];
  assign slot_sum   = {1'b0, h1_r} + {1'b0, off_wrap};
  assign jump_slot  = (slot_sum >= {1'b0, TABLE_SIZE}) ?
                      SLOT_W'(slot_sum - {1'b0, TABLE_SIZE}) : slot_sum[SLOT_W-1:0];
  assign lin_slot   = (slot_r == TABLE_LAST) ? '0 : slot_r + 16'd1;
  assign probes_inc = probes_r + 17'd1;

  // counter entry of an older epoch reads as zero
  assign cnt_live = (crdata.epoch == cur_r);
  assign cur_ctx  = cnt_live ? crdata.ctx : '0;
  assign cur_obj  = cnt_live ? crdata.obj : '0;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tuple_nxt     = tuple_r;
    ctx_nxt       = ctx_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    off_nxt       = off_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    g_nxt         = g_r;
    diff_nxt      = diff_r;
    fail_nxt      = fail_r;
    res_st_nxt    = res_st_r;
    res_sc_nxt    = res_sc_r;
    res_dc_nxt    = res_dc_r;
    mod_start     = hash_go_r;
    hport         = '0;
    cport         = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        hport.we    = 1'b1;
        hport.waddr = sweep_r;
        cport.we    = 1'b1;
        cport.waddr = sweep_r[GEN_W-1:0];
        sweep_nxt   = sweep_r + 16'd1;
        if (sweep_r == TABLE_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          res_st_nxt = ST_OK;
          res_sc_nxt = '0;
          res_dc_nxt = '0;
          unique case (in_tuser)
            REQ_INSERT: begin
              tuple_nxt = in_tdata[TUP_W-1:0];
              ctx_nxt   = in_tdata[TUP_W-1:0] & obj_mask_r;
              state_nxt = S_HASH;
            end
            REQ_READ: begin
              if (in_tdata[TUP_W+GEN_W-1:TUP_W] < cur_r) begin
                cport.re    = 1'b1;
                cport.raddr = in_tdata[TUP_W+GEN_W-1:TUP_W];
                state_nxt   = S_RRD;
              end else begin
                res_st_nxt = ST_RANGE;
                state_nxt  = S_OUT;
              end
            end
            REQ_ADVANCE: begin
              if (cur_r != GENOME_LAST) begin
                cur_nxt = cur_r + 11'd1;
              end else begin
                res_st_nxt = ST_RANGE;
              end
              state_nxt = S_OUT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_HASH: begin
        if (mod_done) begin
          h1_nxt     = rem_t;
          h2_nxt     = rem_t1 + 16'd1;
          off_nxt    = '0;
          slot_nxt   = rem_t;
          probes_nxt = '0;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        hport.re    = 1'b1;
        hport.raddr = slot_r;
        state_nxt   = S_EV;
      end
      S_EV: begin
        if (!hrdata[HWORD_W-1]) begin
          // free slot: store tagged tuple
          hport.we    = 1'b1;
          hport.waddr = slot_r;
          hport.wdata = {1'b1, cur_r, tuple_r};
          state_nxt   = S_OUT;
        end else begin
          probes_nxt = probes_inc;
          fail_nxt   = (probes_inc > TABLE_PRB);
          if (!ctx_hit) begin
            off_nxt  = off_wrap;
            slot_nxt = jump_slot;
          end else begin
            slot_nxt = lin_slot;
          end
          if (ctx_hit && (word_gen < cur_r)) begin
            cport.re    = 1'b1;
            cport.raddr = word_gen;
            g_nxt       = word_gen;
            diff_nxt    = ((word_tup & tuple_mask_r) != tuple_r);
            state_nxt   = S_CRD;
          end else if (probes_inc > TABLE_PRB) begin
            res_st_nxt = ST_PROBE;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_CRD: begin
        // saturating bump, written back under the current epoch
        cport.we          = 1'b1;
        cport.waddr       = g_r;
        cport.wdata.epoch = cur_r;
        cport.wdata.ctx   = (cur_ctx == COUNT_MAX) ? cur_ctx : cur_ctx + 16'd1;
        cport.wdata.obj   = (diff_r && (cur_obj != COUNT_MAX)) ? cur_obj + 16'd1 : cur_obj;
        if (fail_r) begin
          res_st_nxt = ST_PROBE;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RRD: begin
        res_sc_nxt = cur_ctx;
        res_dc_nxt = cur_obj;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, cur_r, res_dc_r, res_sc_r, res_st_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      sweep_r      <= '0;
      cur_r        <= '0;
      obj_mask_r   <= '1;
      tuple_mask_r <= '1;
      out_valid_r  <= 1'b0;
      hash_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      hash_go_r   <= (state_r == S_IDLE) && in_tvalid && (in_tuser == REQ_INSERT);
      if (cfg_valid) begin
        if (cfg_index == CFG_TUPLE_MASK) begin
          tuple_mask_r <= cfg_data;
        end else begin
          obj_mask_r <= cfg_data;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    tuple_r    <= tuple_nxt;
    ctx_r      <= ctx_nxt;
    h1_r       <= h1_nxt;
    h2_r       <= h2_nxt;
    off_r      <= off_nxt;
    slot_r     <= slot_nxt;
    probes_r   <= probes_nxt;
    g_r        <= g_nxt;
    diff_r     <= diff_nxt;
    fail_r     <= fail_nxt;
    res_st_r   <= res_st_nxt;
    res_sc_r   <= res_sc_nxt;
    res_dc_r   <= res_dc_nxt;
  end

endmodule

### rtl/core/pooled_hash_shared_context_counter_chk.sv
// Port-level checker for the pooled hash shared context counter, with its bind.
// Depends on phsc_pkg.
module pooled_hash_shared_context_counter_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import phsc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // only defined status codes come out
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status");

  // failed requests carry no counts
  a_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[33:2] == 32'd0)
    else $error("counts on a failed request");

  // one request at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");
endmodule

bind pooled_hash_shared_context_counter_top pooled_hash_shared_context_counter_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### sim/phsc_checker.sv
`timescale 1ns / 1ps
// Checker for the pooled hash shared context counter: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on phsc_pkg.
module phsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [51:0] cfg_data,
  output int          errors,
  output int          pending
);
  import phsc_pkg::*;

  localparam int unsigned SLOTS = 65521;
  localparam logic [CNT_W:0] SAT = 17'd65535;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] shared;
    logic [CNT_W-1:0] diff;
    logic [GEN_W-1:0] genome;
  } answer_t;

  // model state
  logic [63:0]      slot_mem [SLOTS];
  logic [CNT_W:0]   shared_cnt [CNT_DEPTH];
  logic [CNT_W:0]   diff_cnt [CNT_DEPTH];
  logic [GEN_W-1:0] cur_genome;
  logic [51:0]      ctx_mask;
  logic [51:0]      full_mask;
  answer_t          answers_due [$];

  assign pending = answers_due.size();

  function automatic logic [CNT_W:0] sat_inc(logic [CNT_W:0] c);
    return (c < SAT) ? c + 1'b1 : c;
  endfunction

  // probe for a free slot, counting shared contexts on the way
  function automatic logic [1:0] hash_insert(logic [51:0] tup);
    logic [63:0] ctx, h1, h2, jumps, slot, body, g;
    int probes;
    ctx   = {12'd0, tup & ctx_mask};
    h1    = ctx % SLOTS;
    h2    = 1 + ctx % (SLOTS - 1);
    jumps = 0;
    slot  = h1;
    probes = 0;
    while (slot_mem[slot][63]) begin
      body = {1'b0, slot_mem[slot][62:0]};
      if ({12'd0, body[51:0] & ctx_mask} != ctx) begin
        jumps = (jumps + 1) % SLOTS;
        slot  = (h1 + (jumps * h2) % SLOTS) % SLOTS;
      end else begin
        g = body >> TUP_W;
        if (g < cur_genome) begin
          shared_cnt[g] = sat_inc(shared_cnt[g]);
          if ((body[51:0] & full_mask) != tup) diff_cnt[g] = sat_inc(diff_cnt[g]);
        end
        slot = (slot + 1) % SLOTS;
      end
      probes++;
      if (probes > SLOTS) return ST_PROBE;
    end
    slot_mem[slot] = {1'b1, cur_genome, tup};
    return ST_OK;
  endfunction

  function automatic answer_t serve_request(logic [1:0] req, logic [51:0] tup,
                                            logic [GEN_W-1:0] sel);
    answer_t a;
    a = '0;
    case (req)
      REQ_INSERT: a.status = hash_insert(tup);
      REQ_READ: begin
        if (sel < cur_genome) begin
          a.shared = shared_cnt[sel][CNT_W-1:0];
          a.diff   = diff_cnt[sel][CNT_W-1:0];
        end else begin
          a.status = ST_RANGE;
        end
      end
      REQ_ADVANCE: begin
        if (cur_genome != GENOME_LAST) begin
          for (int i = 0; i < CNT_DEPTH; i++) begin
            shared_cnt[i] = '0;
            diff_cnt[i]   = '0;
          end
          cur_genome = cur_genome + 1'b1;
        end else begin
          a.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    a.genome = cur_genome;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_mem[i] = '0;
      for (int i = 0; i < CNT_DEPTH; i++) begin
        shared_cnt[i] = '0;
        diff_cnt[i]   = '0;
      end
      cur_genome = '0;
      ctx_mask   = '1;
      full_mask  = '1;
      answers_due.delete();
      errors = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[17:2], out_tdata[33:18], out_tdata[44:34]};
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected result beat %h", $realtime, out_tdata);
        end else begin
          want = answers_due.pop_front();
          if (got.status != want.status || got.shared != want.shared ||
              got.diff != want.diff || got.genome != want.genome) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: result mismatch: status %0d/%0d shared %0d/%0d",
                        " diff %0d/%0d genome %0d/%0d (exp/act)"},
                       $realtime, want.status, got.status, want.shared, got.shared,
                       want.diff, got.diff, want.genome, got.genome);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OBJ_MASK) ctx_mask = cfg_data;
        else full_mask = cfg_data;
      end
      if (in_tvalid && in_tready)
        answers_due.push_back(serve_request(in_tuser, in_tdata[51:0], in_tdata[62:52]));
    end
  end

endmodule

### sim/tb_pooled_hash_shared_context_counter_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, request and register stimulus, final verdict.
// Depends on phsc_pkg, pooled_hash_shared_context_counter_top, phsc_checker.
module tb_pooled_hash_shared_context_counter_top;
  import phsc_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [51:0] ALL_ONES = {52{1'b1}};
  localparam logic [51:0] HIGH_CTX = {{20{1'b1}}, 32'd0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0, in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid, out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic        cfg_index = 1'b0;
  logic [51:0] cfg_data = '0;
  int          errors, pending;
  bit          gaps_on = 1'b1;
  int          stall_left = 0;
  longint      cycles = 0;
  int          genome_guess = 0;
  logic [51:0] inserted [$];
  logic [19:0] ctx_pool [8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pooled_hash_shared_context_counter_top dut (.*);

  phsc_checker checker_i (.*);

  // result-side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] req, logic [51:0] tup, logic [GEN_W-1:0] sel);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {1'b0, sel, tup};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == REQ_ADVANCE && genome_guess < 2047) genome_guess++;
    if (req == REQ_INSERT) inserted.push_back(tup);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [51:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [51:0] pick_tuple();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3 && inserted.size() > 0)
      return inserted[$urandom_range(0, inserted.size() - 1)];
    if (r < 5 && inserted.size() > 0)
      return inserted[$urandom_range(0, inserted.size() - 1)] ^ (52'd1 << $urandom_range(0, 31));
    if (r < 8)
      return {ctx_pool[$urandom_range(0, 7)], 32'($urandom)};
    return {20'($urandom), 32'($urandom)};
  endfunction

  task automatic random_requests(int n, bit quiet_tail);
    int r;
    for (int i = 0; i < n; i++) begin
      if (quiet_tail && i > n - n / 5) gaps_on = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 68) send_request(REQ_INSERT, pick_tuple(), 11'($urandom));
      else if (r < 82)
        send_request(REQ_READ, 52'({$urandom, $urandom}), 11'($urandom_range(0, genome_guess)));
      else if (r < 86) send_request(REQ_READ, 52'({$urandom, $urandom}), 11'($urandom));
      else if (r < 97) send_request(REQ_ADVANCE, 52'({$urandom, $urandom}), 11'($urandom));
      else send_request(REQ_UNUSED, 52'({$urandom, $urandom}), 11'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (ctx_pool[i]) ctx_pool[i] = 20'($urandom);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, own-genome skip, counted context, reads, unused kind
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, ALL_ONES, '1);
    send_request(REQ_INSERT, ALL_ONES, '0);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_ADVANCE, '0, '0);
    send_request(REQ_INSERT, ALL_ONES, '0);
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_READ, '0, 11'd0);
    send_request(REQ_READ, '0, 11'd1);
    send_request(REQ_READ, ALL_ONES, '1);
    send_request(REQ_UNUSED, ALL_ONES, '1);
    send_request(REQ_ADVANCE, '0, '0);
    send_request(REQ_READ, '0, 11'd1);
    drain();

    // zero masks: every tuple shares one context, objects differ unless the tuple is zero
    write_reg(CFG_OBJ_MASK, '0);
    write_reg(CFG_TUPLE_MASK, '0);
    for (int i = 0; i < 10; i++) send_request(REQ_INSERT, pick_tuple(), '0);
    send_request(REQ_ADVANCE, '0, '0);
    for (int i = 0; i < 6; i++) send_request(REQ_INSERT, {52{i[0]}} & 52'($urandom), '0);
    send_request(REQ_READ, '0, 11'(genome_guess - 1));
    drain();

    // context in the upper bits, full tuple compared
    write_reg(CFG_OBJ_MASK, HIGH_CTX);
    write_reg(CFG_TUPLE_MASK, ALL_ONES);
    random_requests(650, 1'b0);
    drain();

    // random masks
    write_reg(CFG_OBJ_MASK, HIGH_CTX | 52'($urandom));
    write_reg(CFG_TUPLE_MASK, {20'($urandom), 32'($urandom)});
    random_requests(330, 1'b0);
    drain();
    write_reg(CFG_OBJ_MASK, ALL_ONES);
    write_reg(CFG_TUPLE_MASK, ALL_ONES);
    random_requests(420, 1'b1);

    // closing requests with no idling
    gaps_on = 1'b0;
    send_request(REQ_ADVANCE, '0, '0);
    send_request(REQ_INSERT, pick_tuple(), '0);
    send_request(REQ_READ, '0, 11'(genome_guess - 1));
    send_request(REQ_READ, '0, 11'(genome_guess));
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/phsc_pkg.sv
rtl/core/phsc_hash_ram.sv
rtl/core/phsc_cnt_ram.sv
rtl/core/phsc_mod.sv
rtl/core/pooled_hash_shared_context_counter_top.sv
rtl/core/pooled_hash_shared_context_counter_chk.sv
sim/phsc_checker.sv
sim/tb_pooled_hash_shared_context_counter_top.sv
